>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/blmm_pkg.sv
// ----------------------------------------------------------------------------
// Batched LWE matrix multiply-add package
// Shared constants, codes and types of the multiply-add unit.
// ----------------------------------------------------------------------------
package blmm_pkg;

	localparam int WORD_W        = 16;
	localparam int LANES         = 8;
	localparam int ROWS          = 8;
	localparam int COLUMNS_DEF   = 640;
	localparam int INSTANCES_DEF = 4;

	localparam int IN_DATA_W  = 168;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		MODE_LOAD_ERR = 2'd0,
		MODE_LOAD_SEC = 2'd1,
		MODE_COLUMN   = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COL,
		ST_DRAIN,
		ST_RD
	} state_t;

endpackage

>>> design/blmm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/blmm_lane.sv
// ----------------------------------------------------------------------------
// Multiply lane
// One secret coefficient times one A value, low 16 bits, registered.
// ----------------------------------------------------------------------------
module blmm_lane
	import blmm_pkg::*;
(
	input  logic              clk,
	input  logic [WORD_W-1:0] secret,
	input  logic [WORD_W-1:0] a_val,
	output logic [WORD_W-1:0] product_s2
);

	logic [WORD_W-1:0] full;

	assign full = secret * a_val;

	// keep only the low word: the sum wraps at 16 bits anyway
	always_ff @(posedge clk) begin
		product_s2 <= full;
	end

endmodule

>>> design/blmm_merge.sv
// ----------------------------------------------------------------------------
// Lane merge
// Adds the lane products onto the old accumulator word, wrapping at 16 bits.
// ----------------------------------------------------------------------------
module blmm_merge
	import blmm_pkg::*;
(
	input  logic [LANES-1:0][WORD_W-1:0] products,
	input  logic [WORD_W-1:0]            acc_old,
	output logic [WORD_W-1:0]            acc_new
);

	always_comb begin
		logic [WORD_W-1:0] sum;
		sum = acc_old;
		for (int p = 0; p < LANES; p++) begin
			sum = sum + products[p];
		end
		acc_new = sum;
	end

endmodule

>>> design/batched_lwe_matrix_mul_add_unit.sv
// ----------------------------------------------------------------------------
// Batched LWE matrix multiply-add unit
// out = s'*A + e' modulo 2^16 for up to four instances, eight lanes wide.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer carries
//  s_axis    in         tuser: mode; tdata: instance_req, row, column, slab,
//                       word, a_low, a_high
//  m_axis    out        tdata: value (read results only)
//
//  A load writes its store in the transfer cycle. A column item starts with
//  the transfer, then one instance row per cycle is read from the eight
//  secret banks and the accumulator, multiplied in eight lanes, merged and
//  written back, then the two pipeline stages drain before s_axis opens again.
//  A read stalls in ST_RD while m_axis holds an earlier result; loads and
//  column items are still taken while a result waits in the output register.
//  Reset clears control state only; both stores are undefined until written.
//
`include "assert_macros.svh"

module batched_lwe_matrix_mul_add_unit
	import blmm_pkg::*;
#(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int INSTANCES = INSTANCES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_axis
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, lowest bit up: instance_req[1:0], row[4:2], column[14:5],
	// slab[21:15], word[37:22], a_low[101:38], a_high[165:102], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	// m_axis
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: value[15:0]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// Store geometry: the accumulator is one memory; the secret is split into
	// eight banks by column modulo eight so that all words of a slab read together.
	localparam int IR_COUNT   = INSTANCES * ROWS;
	localparam int IRW        = $clog2(IR_COUNT);
	localparam int ACC_DEPTH  = IR_COUNT * COLUMNS;
	localparam int AAW        = $clog2(ACC_DEPTH);
	localparam int SLOTS      = (COLUMNS + LANES - 1) / LANES;
	localparam int BANK_DEPTH = IR_COUNT * SLOTS;
	localparam int BAW        = $clog2(BANK_DEPTH);
	localparam int LSW        = $clog2(LANES);

	// Unpack the input transfer.
	mode_t                      in_mode;
	logic [1:0]                 in_inst;
	logic [2:0]                 in_row;
	logic [9:0]                 in_col;
	logic [6:0]                 in_slab;
	logic [WORD_W-1:0]          in_word;
	logic [LANES-1:0][WORD_W-1:0] in_a;

	assign in_mode = mode_t'(s_axis_tuser[1:0]);
	assign in_inst = s_axis_tdata[1:0];
	assign in_row  = s_axis_tdata[4:2];
	assign in_col  = s_axis_tdata[14:5];
	assign in_slab = s_axis_tdata[21:15];
	assign in_word = s_axis_tdata[37:22];
	assign in_a    = s_axis_tdata[165:38];

	logic in_xfer;
	logic in_ok;
	logic col_ok;
	int   in_ir;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign in_ok   = (int'(in_inst) < INSTANCES) && (int'(in_col) < COLUMNS);
	assign col_ok  = (int'(in_col) < COLUMNS) &&
		(int'(in_slab) * LANES + (LANES - 1) < COLUMNS);
	assign in_ir   = int'(in_inst) * ROWS + int'(in_row);

	// Control registers.
	state_t             state_q, state_d;
	logic [IRW-1:0]     k_q;
	logic [9:0]         col_q;
	logic [6:0]         slab_q;
	logic [LANES-1:0][WORD_W-1:0] a_q;
	logic               rd_zero_q;
	logic               v_s1, v_s2;
	logic [IRW-1:0]     k_s1, k_s2;
	logic [WORD_W-1:0]  acc_s2;
	logic [WORD_W-1:0]  out_q;
	logic               out_valid_q;

	// Output decode.
	logic issue;
	logic out_load;
	logic k_last;

	assign k_last = (k_q == IRW'(IR_COUNT - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_mode == MODE_COLUMN && col_ok) begin
					state_d = ST_COL;
				end else if (in_xfer && in_mode == MODE_READ) begin
					state_d = ST_RD;
				end
			end
			ST_COL: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_COL:   issue = 1'b1;
			ST_DRAIN: ;
			ST_RD:    out_load = !out_valid_q || m_axis_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// advance the instance-row sweep; restart it at each column item
			if (issue) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the column item and the pipeline data.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q     <= in_col;
			slab_q    <= in_slab;
			a_q       <= in_a;
			rd_zero_q <= !in_ok;
		end
		k_s1 <= k_q;
		k_s2 <= k_s1;
	end

	// Accumulator store.
	logic             acc_wr_en;
	logic [AAW-1:0]   acc_wr_addr;
	logic [WORD_W-1:0] acc_wr_data;
	logic             acc_rd_en;
	logic [AAW-1:0]   acc_rd_addr;
	logic [WORD_W-1:0] acc_rd_data;
	logic [WORD_W-1:0] acc_new;
	logic [AAW-1:0]   in_acc_addr;

	assign in_acc_addr = AAW'(in_ir * COLUMNS + int'(in_col));

	always_comb begin
		if (v_s2) begin
			acc_wr_en   = 1'b1;
			acc_wr_addr = AAW'(int'(k_s2) * COLUMNS + int'(col_q));
			acc_wr_data = acc_new;
		end else begin
			acc_wr_en   = in_xfer && in_mode == MODE_LOAD_ERR && in_ok;
			acc_wr_addr = in_acc_addr;
			acc_wr_data = in_word;
		end
		if (issue) begin
			acc_rd_en   = 1'b1;
			acc_rd_addr = AAW'(int'(k_q) * COLUMNS + int'(col_q));
		end else begin
			acc_rd_en   = in_xfer && in_mode == MODE_READ && in_ok;
			acc_rd_addr = in_acc_addr;
		end
	end

	blmm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ACC_DEPTH)
	) u_acc_ram (
		.clk     (clk),
		.wr_en   (acc_wr_en),
		.wr_addr (acc_wr_addr),
		.wr_data (acc_wr_data),
		.rd_en   (acc_rd_en),
		.rd_addr (acc_rd_addr),
		.rd_data (acc_rd_data)
	);

	// Stage 2: carry the old accumulator word beside the lane products.
	always_ff @(posedge clk) begin
		acc_s2 <= acc_rd_data;
	end

	// Secret banks and multiply lanes.
	logic [BAW-1:0]               sec_wr_addr;
	logic [BAW-1:0]               sec_rd_addr;
	logic                         sec_load;
	logic [LANES-1:0][WORD_W-1:0] sec_rd_data;
	logic [LANES-1:0][WORD_W-1:0] products_s2;

	assign sec_load    = in_xfer && in_mode == MODE_LOAD_SEC && in_ok;
	assign sec_wr_addr = BAW'(in_ir * SLOTS + int'(in_col[9:LSW]));
	assign sec_rd_addr = BAW'(int'(k_q) * SLOTS + int'(slab_q));

	for (genvar p = 0; p < LANES; p++) begin : g_lane
		blmm_ram #(
			.WIDTH(WORD_W),
			.DEPTH(BANK_DEPTH)
		) u_sec_ram (
			.clk     (clk),
			.wr_en   (sec_load && in_col[LSW-1:0] == LSW'(p)),
			.wr_addr (sec_wr_addr),
			.wr_data (in_word),
			.rd_en   (issue),
			.rd_addr (sec_rd_addr),
			.rd_data (sec_rd_data[p])
		);

		blmm_lane u_lane (
			.clk        (clk),
			.secret     (sec_rd_data[p]),
			.a_val      (a_q[p]),
			.product_s2 (products_s2[p])
		);
	end

	blmm_merge u_merge (
		.products (products_s2),
		.acc_old  (acc_s2),
		.acc_new  (acc_new)
	);

	// Output register: hold the read result until m_axis takes the transfer.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rd_zero_q ? '0 : acc_rd_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Checks.
	`ASSERT_IMPLIES(a_wb_busy, v_s2, state_q != ST_IDLE, "write-back while idle")
	`ASSERT_NEXT(a_pipe_adv, v_s1, v_s2, "pipeline stage dropped")
	`ASSERT_NEXT(a_read_wait, in_xfer && in_mode == MODE_READ, state_q == ST_RD, "read lost")

endmodule

>>> dv/batched_lwe_matrix_mul_add_unit_tb.sv
// ----------------------------------------------------------------------------
// Batched LWE matrix multiply-add unit testbench
// Walks a short table of directed transfers, then a long random mix of loads,
// A columns and reads. It checks each m_axis transfer in order against a word
// predicted from its own copy of both stores or typed into the directed table.
// ----------------------------------------------------------------------------
module batched_lwe_matrix_mul_add_unit_tb;
	import blmm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS      = COLUMNS_DEF;
	localparam int INSTANCES    = INSTANCES_DEF;
	localparam int STORE_DEPTH  = INSTANCES * ROWS * COLUMNS;
	localparam int SLABS        = COLUMNS / LANES;
	localparam int RANDOM_ITEMS = 2000;
	localparam int QUIET_FROM   = 1700;
	localparam int HOLD_AT      = 700;
	localparam int PAUSE_AT     = 1200;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_ITEMS   = 60;
	// margin after the last read for a column item still in flight to finish
	localparam int DRAIN_CYCLES = 48;

	// One s_axis transfer, field by field
	typedef struct {
		mode_t       mode;
		logic [1:0]  inst;
		logic [2:0]  row;
		logic [9:0]  column;
		logic [6:0]  slab;
		logic [15:0] word;
		logic [63:0] a_low;
		logic [63:0] a_high;
	} xfer_t;

	// A row of the directed table; fixed marks a result typed in by hand in fixed_value
	typedef struct {
		xfer_t       x;
		bit          fixed;
		logic [15:0] fixed_value;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Predicted state of both stores, with a written mark per word
	logic [15:0] secret_words [STORE_DEPTH];
	logic [15:0] acc_words    [STORE_DEPTH];
	bit          secret_known [STORE_DEPTH];
	bit          acc_known    [STORE_DEPTH];

	logic [15:0] pending_values [$];
	logic [15:0] oldest_value;
	int          fail_count = 0;
	int          useful_items = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	// Columns and slabs that most column items and reads work on
	logic [9:0]  col_pool [8];
	logic [6:0]  slab_pool [3];

	dir_row_t    dir_table [$];

	always #6 clk = ~clk;

	batched_lwe_matrix_mul_add_unit #(
		.COLUMNS   (COLUMNS),
		.INSTANCES (INSTANCES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic int unsigned cell_index(input int unsigned inst, input int unsigned row,
		input int unsigned column);
		return (inst * ROWS + row) * COLUMNS + column;
	endfunction

	function automatic xfer_t xfer(input mode_t mode, input logic [1:0] inst,
		input logic [2:0] row, input logic [9:0] column, input logic [6:0] slab,
		input logic [15:0] word, input logic [63:0] a_low, input logic [63:0] a_high);
		xfer_t x;
		x.mode   = mode;
		x.inst   = inst;
		x.row    = row;
		x.column = column;
		x.slab   = slab;
		x.word   = word;
		x.a_low  = a_low;
		x.a_high = a_high;
		return x;
	endfunction

	function automatic dir_row_t dir_row(input xfer_t x, input bit fixed,
		input logic [15:0] fixed_value);
		dir_row_t d;
		d.x           = x;
		d.fixed       = fixed;
		d.fixed_value = fixed_value;
		return d;
	endfunction

	// Apply one transfer to the predicted stores. produces marks a read,
	// effective marks a transfer that the block does not simply ignore.
	function automatic void mul_add_predict(input xfer_t x, output bit produces,
		output bit effective, output logic [15:0] value);
		logic [15:0] lane [LANES];
		logic [15:0] sum;
		logic [15:0] prod;
		int unsigned base;
		int unsigned at;
		bit          in_range;
		produces  = 1'b0;
		effective = 1'b0;
		value     = '0;
		in_range  = (x.inst < INSTANCES) && (x.column < COLUMNS);
		at        = cell_index(32'(x.inst), 32'(x.row), 32'(x.column));
		case (x.mode)
			MODE_LOAD_ERR: begin
				if (in_range) begin
					acc_words[at] = x.word;
					acc_known[at] = 1'b1;
					effective = 1'b1;
				end
			end
			MODE_LOAD_SEC: begin
				if (in_range) begin
					secret_words[at] = x.word;
					secret_known[at] = 1'b1;
					effective = 1'b1;
				end
			end
			MODE_COLUMN: begin
				// drop items whose column or slab falls outside the matrix
				if (x.column < COLUMNS && x.slab < SLABS) begin
					effective = 1'b1;
					base = x.slab * LANES;
					for (int p = 0; p < 4; p++) begin
						lane[p]     = x.a_low[16*p +: 16];
						lane[p + 4] = x.a_high[16*p +: 16];
					end
					for (int i = 0; i < INSTANCES; i++) begin
						for (int r = 0; r < ROWS; r++) begin
							sum = acc_words[cell_index(i, r, 32'(x.column))];
							for (int p = 0; p < LANES; p++) begin
								prod = secret_words[cell_index(i, r, base + p)] * lane[p];
								sum  = sum + prod;
							end
							acc_words[cell_index(i, r, 32'(x.column))] = sum;
						end
					end
				end
			end
			default: begin
				produces  = 1'b1;
				effective = 1'b1;
				value     = in_range ? acc_words[at] : 16'h0000;
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] pick_lanes();
		case ($urandom_range(0, 9))
			0:       return 64'h0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one transfer and hold it until the block takes it
	task automatic issue(input xfer_t x, input bit fixed, input logic [15:0] fixed_value);
		bit          produces;
		bit          effective;
		logic [15:0] value;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		mul_add_predict(x, produces, effective, value);
		if (produces)
			pending_values.push_back(fixed ? fixed_value : value);
		if (effective)
			useful_items++;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= x.mode;
		s_axis_tdata  <= {2'b00, x.a_high, x.a_low, x.word, x.slab, x.column, x.row, x.inst};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Load every word a column item will use that was never written
	task automatic prime_column(input logic [9:0] column, input logic [6:0] slab,
		input bit random_fill, input logic [15:0] fill);
		int unsigned base;
		base = slab * LANES;
		for (int i = 0; i < INSTANCES; i++) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int p = 0; p < LANES; p++) begin
					if (!secret_known[cell_index(i, r, base + p)])
						issue(xfer(MODE_LOAD_SEC, 2'(i), 3'(r), 10'(base + p), 7'($urandom),
							random_fill ? pick_word() : fill, 64'h0, 64'h0), 1'b0, '0);
				end
				if (!acc_known[cell_index(i, r, 32'(column))])
					issue(xfer(MODE_LOAD_ERR, 2'(i), 3'(r), column, 7'($urandom),
						random_fill ? pick_word() : fill, 64'h0, 64'h0), 1'b0, '0);
			end
		end
	endtask

	// Read a written accumulator word, loading one first where needed
	task automatic read_action();
		logic [9:0] column;
		logic [1:0] inst;
		logic [2:0] row;
		column = col_pool[$urandom_range(0, 7)];
		inst   = 2'($urandom);
		row    = 3'($urandom);
		if (!acc_known[cell_index(32'(inst), 32'(row), 32'(column))])
			issue(xfer(MODE_LOAD_ERR, inst, row, column, 7'($urandom), pick_word(),
				pick_lanes(), pick_lanes()), 1'b0, '0);
		issue(xfer(MODE_READ, inst, row, column, 7'($urandom), 16'($urandom),
			pick_lanes(), pick_lanes()), 1'b0, '0);
	endtask

	task automatic load_action(input mode_t mode);
		logic [9:0] column;
		if ($urandom_range(0, 1) == 0)
			column = (mode == MODE_LOAD_SEC) ?
				10'(slab_pool[$urandom_range(0, 2)] * LANES + $urandom_range(0, 7)) :
				col_pool[$urandom_range(0, 7)];
		else
			column = 10'($urandom_range(0, 1023));
		issue(xfer(mode, 2'($urandom), 3'($urandom), column, 7'($urandom), pick_word(),
			pick_lanes(), pick_lanes()), 1'b0, '0);
	endtask

	task automatic random_action();
		int unsigned pick;
		logic [9:0]  column;
		logic [6:0]  slab;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			slab   = slab_pool[$urandom_range(0, 2)];
			column = ($urandom_range(0, 99) < 97) ? col_pool[$urandom_range(0, 7)] :
				10'($urandom_range(0, COLUMNS - 1));
			prime_column(column, slab, 1'b1, '0);
			issue(xfer(MODE_COLUMN, 2'($urandom), 3'($urandom), column, slab,
				16'($urandom), pick_lanes(), pick_lanes()), 1'b0, '0);
		end else if (pick < 60) begin
			read_action();
		end else if (pick < 72) begin
			load_action(MODE_LOAD_ERR);
		end else if (pick < 84) begin
			load_action(MODE_LOAD_SEC);
		end else begin
			// noise: column items the block drops, reads beyond the last column
			case ($urandom_range(0, 2))
				0: issue(xfer(MODE_COLUMN, 2'($urandom), 3'($urandom),
					10'($urandom_range(COLUMNS, 1023)), 7'($urandom), 16'($urandom),
					pick_lanes(), pick_lanes()), 1'b0, '0);
				1: issue(xfer(MODE_COLUMN, 2'($urandom), 3'($urandom),
					10'($urandom_range(0, 1023)), 7'($urandom_range(SLABS, 127)),
					16'($urandom), pick_lanes(), pick_lanes()), 1'b0, '0);
				default: issue(xfer(MODE_READ, 2'($urandom), 3'($urandom),
					10'($urandom_range(COLUMNS, 1023)), 7'($urandom), 16'($urandom),
					pick_lanes(), pick_lanes()), 1'b0, '0);
			endcase
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check every m_axis transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_values.size() == 0) begin
				$error("value: expected none, actual %h", m_axis_tdata);
				fail_count++;
			end else begin
				oldest_value = pending_values.pop_front();
				if (m_axis_tdata !== oldest_value) begin
					$error("value: expected %h, actual %h", oldest_value, m_axis_tdata);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("batched_lwe_matrix_mul_add_unit regression: fail");
		$finish;
	end

	initial begin
		bit hold_done;
		bit pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		col_pool[0] = 10'd0;
		col_pool[1] = 10'(COLUMNS - 1);
		for (int k = 2; k < 8; k++)
			col_pool[k] = 10'($urandom_range(1, COLUMNS - 2));
		slab_pool[0] = 7'd0;
		slab_pool[1] = 7'(SLABS - 1);
		slab_pool[2] = 7'($urandom_range(1, SLABS - 2));

		// Directed table: extremes, every mode and the dropped cases.
		// Column rows carry in word the fill for any secret or error word
		// they need that is not yet written.
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd0, 3'd0, 10'd1023, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b1, 16'h0000));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_ERR, 2'd0, 3'd0, 10'd0, 7'd0, 16'h0000,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd0, 3'd0, 10'd0, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b1, 16'h0000));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_ERR, 2'd3, 3'd7, 10'd639, 7'd127, 16'hFFFF,
			'1, '1), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd3, 3'd7, 10'd639, 7'd127, 16'hFFFF,
			'1, '1), 1'b1, 16'hFFFF));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_SEC, 2'd3, 3'd7, 10'd639, 7'd0, 16'hFFFF,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_ERR, 2'd0, 3'd0, 10'd640, 7'd0, 16'h1234,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd0, 3'd0, 10'd640, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b1, 16'h0000));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd2, 3'd5, 10'd1023, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b1, 16'h0000));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_SEC, 2'd1, 3'd1, 10'd1023, 7'd0, 16'hBEEF,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd0, 7'd0, 16'hFFFF,
			'1, '1), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd0, 3'd0, 10'd0, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd3, 3'd7, 10'd0, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd639, 7'd79, 16'h8000,
			64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd3, 3'd7, 10'd639, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd640, 7'd0, 16'h0,
			'1, '1), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd5, 7'd80, 16'h0,
			'1, '1), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd1, 7'd127, 16'h0,
			'1, '1), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd0, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd0, 3'd0, 10'd0, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_COLUMN, 2'd0, 3'd0, 10'd639, 7'd0, 16'h0,
			64'h0004_0003_0002_0001, 64'h0008_0007_0006_0005), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd1, 3'd3, 10'd639, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_LOAD_ERR, 2'd2, 3'd4, 10'd100, 7'd0, 16'hA5A5,
			64'h0, 64'h0), 1'b0, '0));
		dir_table.push_back(dir_row(xfer(MODE_READ, 2'd2, 3'd4, 10'd100, 7'd0, 16'h0,
			64'h0, 64'h0), 1'b1, 16'hA5A5));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[n]) begin
			if (dir_table[n].x.mode == MODE_COLUMN && dir_table[n].x.column < COLUMNS &&
				dir_table[n].x.slab < SLABS)
				prime_column(dir_table[n].x.column, dir_table[n].x.slab, 1'b0,
					dir_table[n].x.word);
			issue(dir_table[n].x, dir_table[n].fixed, dir_table[n].fixed_value);
		end

		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			if (useful_items >= QUIET_FROM)
				quiet = 1'b1;
			if (!hold_done && useful_items >= HOLD_AT) begin
				// hold m_axis off and keep offering reads and error loads so the input stalls
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (HOLD_ITEMS) begin
					if ($urandom_range(0, 9) < 7)
						read_action();
					else
						load_action(MODE_LOAD_ERR);
				end
			end else if (!pause_done && useful_items >= PAUSE_AT) begin
				// drop tvalid until every read result has come back
				pause_done = 1'b1;
				s_axis_tvalid <= 1'b0;
				while (pending_values.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end else begin
				random_action();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("batched_lwe_matrix_mul_add_unit regression: pass");
		else
			$display("batched_lwe_matrix_mul_add_unit regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/blmm_pkg.sv
design/blmm_ram.sv
design/blmm_lane.sv
design/blmm_merge.sv
design/batched_lwe_matrix_mul_add_unit.sv
dv/batched_lwe_matrix_mul_add_unit_tb.sv
